/* hw/rtl/s3p_pkg.sv */
// ----------------------------------------------------------------------------
// s3p_pkg: shared types and round functions
// Word types, pipeline payload structs, round constants and the SHA-256
// round primitives used by the three-round precompute pipeline.
// ----------------------------------------------------------------------------
package s3p_pkg;

    typedef logic [31:0] t_word;

    localparam int unsigned NUM_ROUNDS = 3;

    localparam t_word ROUND_K [NUM_ROUNDS] = '{32'h428a2f98, 32'h71374491, 32'hb5c0fbcf};

    // Working variables a..h
    typedef struct packed {
        t_word a;
        t_word b;
        t_word c;
        t_word d;
        t_word e;
        t_word f;
        t_word g;
        t_word h;
    } t_vars;

    // Item between rounds: kw is K plus message word for the coming round,
    // w holds the message words still to come (w[0] next).
    typedef struct packed {
        t_vars                 v;
        t_word                 kw;
        logic [1:0][31:0]      w;
        logic [2:0][31:0]      na;
        logic [2:0][31:0]      ne;
    } t_work;

    // Item between the two halves of a round
    typedef struct packed {
        t_vars                 v;
        t_word                 t1;
        t_word                 t2;
        logic [1:0][31:0]      w;
        logic [2:0][31:0]      na;
        logic [2:0][31:0]      ne;
    } t_half;

    function automatic t_word rotr(input t_word x, input int unsigned s);
        rotr = (x >> s) | (x << (32 - s));
    endfunction

    function automatic t_word big_sigma0(input t_word x);
        big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic t_word big_sigma1(input t_word x);
        big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic t_word choose(input t_word e, input t_word f, input t_word g);
        choose = g ^ (e & (f ^ g));
    endfunction

    function automatic t_word majority(input t_word a, input t_word b, input t_word c);
        majority = (a & b) | (c & (a | b));
    endfunction

endpackage

/* hw/rtl/s3p_if.sv */
// ----------------------------------------------------------------------------
// s3p_in_if / s3p_out_if: valid/ready channels
// Input channel carries the midstate and three message words; output
// channel carries the new a and e words of the three rounds.
// ----------------------------------------------------------------------------
interface s3p_in_if;
    logic           valid;
    logic           ready;
    logic [31:0]    mid_a;
    logic [31:0]    mid_b;
    logic [31:0]    mid_c;
    logic [31:0]    mid_d;
    logic [31:0]    mid_e;
    logic [31:0]    mid_f;
    logic [31:0]    mid_g;
    logic [31:0]    mid_h;
    logic [31:0]    msg_word0;
    logic [31:0]    msg_word1;
    logic [31:0]    msg_word2;

    modport source (
        output valid, mid_a, mid_b, mid_c, mid_d, mid_e, mid_f, mid_g, mid_h,
               msg_word0, msg_word1, msg_word2,
        input  ready
    );
    modport sink (
        input  valid, mid_a, mid_b, mid_c, mid_d, mid_e, mid_f, mid_g, mid_h,
               msg_word0, msg_word1, msg_word2,
        output ready
    );
endinterface

interface s3p_out_if;
    logic           valid;
    logic           ready;
    logic [31:0]    round0_new_a;
    logic [31:0]    round1_new_a;
    logic [31:0]    round2_new_a;
    logic [31:0]    round0_new_e;
    logic [31:0]    round1_new_e;
    logic [31:0]    round2_new_e;

    modport source (
        output valid, round0_new_a, round1_new_a, round2_new_a,
               round0_new_e, round1_new_e, round2_new_e,
        input  ready
    );
    modport sink (
        input  valid, round0_new_a, round1_new_a, round2_new_a,
               round0_new_e, round1_new_e, round2_new_e,
        output ready
    );
endinterface

/* hw/rtl/s3p_round.sv */
// ----------------------------------------------------------------------------
// s3p_round: one SHA-256 compression round in two register stages
// Stage A forms T1 and T2, stage B forms the new a and e words and the
// K plus W sum for the following round.
// ----------------------------------------------------------------------------
module s3p_round (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  s3p_pkg::t_word  i_k_next,
    input  logic            i_vld,
    output logic            o_rdy,
    input  s3p_pkg::t_work  i_data,
    output logic            o_vld,
    input  logic            i_rdy,
    output s3p_pkg::t_work  o_data
);

    logic            r_vld_a;
    logic            r_vld_b;
    s3p_pkg::t_half  r_half;
    s3p_pkg::t_half  n_half;
    s3p_pkg::t_work  r_work;
    s3p_pkg::t_work  n_work;
    logic            w_en_a;
    logic            w_en_b;

    // a stage advances when empty or when its contents move on
    assign w_en_b = !r_vld_b || i_rdy;
    assign w_en_a = !r_vld_a || w_en_b;
    assign o_rdy  = w_en_a;

    always_comb begin
        n_half    = '0;
        n_half.v  = i_data.v;
        n_half.t1 = i_data.v.h + s3p_pkg::big_sigma1(i_data.v.e)
                  + s3p_pkg::choose(i_data.v.e, i_data.v.f, i_data.v.g) + i_data.kw;
        n_half.t2 = s3p_pkg::big_sigma0(i_data.v.a)
                  + s3p_pkg::majority(i_data.v.a, i_data.v.b, i_data.v.c);
        n_half.w  = i_data.w;
        n_half.na = i_data.na;
        n_half.ne = i_data.ne;
    end

    always_comb begin
        n_work     = '0;
        n_work.v.h = r_half.v.g;
        n_work.v.g = r_half.v.f;
        n_work.v.f = r_half.v.e;
        n_work.v.e = r_half.v.d + r_half.t1;
        n_work.v.d = r_half.v.c;
        n_work.v.c = r_half.v.b;
        n_work.v.b = r_half.v.a;
        n_work.v.a = r_half.t1 + r_half.t2;
        n_work.kw  = i_k_next + r_half.w[0];
        n_work.w   = {32'h0, r_half.w[1]};
        // shift in this round's results: index 0 is the latest round
        n_work.na  = {r_half.na[1:0], n_work.v.a};
        n_work.ne  = {r_half.ne[1:0], n_work.v.e};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_a <= 1'b0;
            r_vld_b <= 1'b0;
        end else begin
            if (w_en_a) r_vld_a <= i_vld;
            if (w_en_b) r_vld_b <= r_vld_a;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en_a) r_half <= n_half;
        if (w_en_b) r_work <= n_work;
    end

    assign o_vld  = r_vld_b;
    assign o_data = r_work;

endmodule

/* hw/rtl/sha256_three_round_precalc_core.sv */
// ----------------------------------------------------------------------------
// sha256_three_round_precalc_core: first three SHA-256 rounds from a midstate
// Pipelined precompute of the new a and e words of rounds zero to two.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries one work item: midstate words mid_a..mid_h and the message
//   words msg_word0..msg_word2. A transfer happens when valid and ready are
//   both high at a rising edge of i_clk.
//   o_out carries one result per item: round0..2_new_a and round0..2_new_e,
//   in the order the items were taken.
//   The result reaches o_out through an input register, then two register
//   stages per round for three rounds. Throughput: one item per cycle,
//   sustained while o_out.ready is high; every stage holds one item.
//   Stall: when o_out.ready is low the last stage holds its result; earlier
//   stages keep filling until they are all occupied, and only then does
//   i_in.ready drop. No item is lost or repeated.
//   Reset: i_rst_n is synchronous, active low, and empties the pipeline; the
//   block keeps no other state.
// ----------------------------------------------------------------------------
module sha256_three_round_precalc_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    s3p_in_if.sink      i_in,
    s3p_out_if.source   o_out
);

    logic            r_in_vld;
    s3p_pkg::t_work  r_in;
    s3p_pkg::t_work  n_in;
    logic            w_en_in;

    logic            w_vld [3];
    logic            w_rdy [3];
    s3p_pkg::t_work  w_data [3];

    assign w_en_in    = !r_in_vld || w_rdy[0];
    assign i_in.ready = w_en_in;

    always_comb begin
        n_in      = '0;
        n_in.v.a  = i_in.mid_a;
        n_in.v.b  = i_in.mid_b;
        n_in.v.c  = i_in.mid_c;
        n_in.v.d  = i_in.mid_d;
        n_in.v.e  = i_in.mid_e;
        n_in.v.f  = i_in.mid_f;
        n_in.v.g  = i_in.mid_g;
        n_in.v.h  = i_in.mid_h;
        n_in.kw   = s3p_pkg::ROUND_K[0] + i_in.msg_word0;
        n_in.w    = {i_in.msg_word2, i_in.msg_word1};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (w_en_in) begin
            r_in_vld <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en_in) r_in <= n_in;
    end

    s3p_round u_round0 (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_k_next (s3p_pkg::ROUND_K[1]),
        .i_vld    (r_in_vld),
        .o_rdy    (w_rdy[0]),
        .i_data   (r_in),
        .o_vld    (w_vld[0]),
        .i_rdy    (w_rdy[1]),
        .o_data   (w_data[0])
    );

    s3p_round u_round1 (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_k_next (s3p_pkg::ROUND_K[2]),
        .i_vld    (w_vld[0]),
        .o_rdy    (w_rdy[1]),
        .i_data   (w_data[0]),
        .o_vld    (w_vld[1]),
        .i_rdy    (w_rdy[2]),
        .o_data   (w_data[1])
    );

    // no round follows the last one, so its K plus W sum goes unused
    s3p_round u_round2 (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_k_next (32'h0),
        .i_vld    (w_vld[1]),
        .o_rdy    (w_rdy[2]),
        .i_data   (w_data[1]),
        .o_vld    (w_vld[2]),
        .i_rdy    (o_out.ready),
        .o_data   (w_data[2])
    );

    assign o_out.valid        = w_vld[2];
    assign o_out.round0_new_a = w_data[2].na[2];
    assign o_out.round1_new_a = w_data[2].na[1];
    assign o_out.round2_new_a = w_data[2].na[0];
    assign o_out.round0_new_e = w_data[2].ne[2];
    assign o_out.round1_new_e = w_data[2].ne[1];
    assign o_out.round2_new_e = w_data[2].ne[0];

    // backpressure reaches the input only from a held result at the output
    a_stall_from_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> (o_out.valid && !o_out.ready))
        else $error("input stalled without a held output");

    // a full pipeline stalls the input only while every stage is occupied
    a_full_before_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> (r_in_vld && w_vld[0] && w_vld[1] && w_vld[2]))
        else $error("input stalled with an empty stage");

    // pipeline is empty right after reset
    a_empty_after_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> (!o_out.valid && !r_in_vld))
        else $error("pipeline not empty after reset");

    // hold a waiting item in the input register until round zero takes it
    a_input_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && !w_rdy[0]) |=> (r_in_vld && $stable(r_in)))
        else $error("input register changed while stalled");

endmodule
